>>> sv/cpps_pkg.sv
// Shared types, codes and the result table of the charger probe sequencer.
package cpps_pkg;

  // Input word: one event.
  typedef struct packed {
    logic [2:0]  func;
    logic        probe_ok;
    logic [7:0]  bus_volts;
    logic [13:0] bus_frac;
  } in_word_t;

  // Output word: one result.
  typedef struct packed {
    logic        report_valid;
    logic [3:0]  report_kind;
    logic        report_supported;
    logic [3:0]  command;
    logic [15:0] timer_ms;
    logic        last;
  } out_word_t;

  // Configuration registers.
  typedef struct packed {
    logic [3:0]  qc2_window_volts;
    logic [15:0] qc3_step_size;
    logic [15:0] qc3_window;
    logic [15:0] settle_time_ms;
    logic [15:0] release_time_ms;
  } cfg_t;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_QC2_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QC3_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QC3_WINDOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE    = 3'd4;

  localparam logic [3:0]  RST_QC2_WINDOW = 4'd1;
  localparam logic [15:0] RST_QC3_STEP   = 16'd2000;
  localparam logic [15:0] RST_QC3_WINDOW = 16'd500;
  localparam logic [15:0] RST_SETTLE     = 16'd1000;
  localparam logic [15:0] RST_RELEASE    = 16'd500;

  localparam int QUEUE_DEPTH_DEF = 4;

  // Event codes.
  localparam logic [2:0] EV_START  = 3'd0;
  localparam logic [2:0] EV_DCP    = 3'd1;
  localparam logic [2:0] EV_QC2    = 3'd2;
  localparam logic [2:0] EV_TIMER  = 3'd3;
  localparam logic [2:0] EV_PORT21 = 3'd4;
  localparam logic [2:0] EV_PD     = 3'd5;

  // Report kinds.
  localparam logic [3:0] RK_FINISHED = 4'd0;
  localparam logic [3:0] RK_DCP      = 4'd1;
  localparam logic [3:0] RK_QC2      = 4'd2;
  localparam logic [3:0] RK_9V       = 4'd3;
  localparam logic [3:0] RK_12V      = 4'd4;
  localparam logic [3:0] RK_20V      = 4'd5;
  localparam logic [3:0] RK_QC3      = 4'd6;
  localparam logic [3:0] RK_PORT21   = 4'd7;
  localparam logic [3:0] RK_PD       = 4'd8;

  // Commands.
  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_PORT      = 4'd1;
  localparam logic [3:0] CMD_QC2       = 4'd2;
  localparam logic [3:0] CMD_9V        = 4'd3;
  localparam logic [3:0] CMD_12V       = 4'd4;
  localparam logic [3:0] CMD_20V       = 4'd5;
  localparam logic [3:0] CMD_5V        = 4'd6;
  localparam logic [3:0] CMD_QC3_MODE  = 4'd7;
  localparam logic [3:0] CMD_QC3_UP    = 4'd8;
  localparam logic [3:0] CMD_STOP_QC   = 4'd9;
  localparam logic [3:0] CMD_ENTER_PD  = 4'd10;
  localparam logic [3:0] CMD_EXIT_PD   = 4'd11;

  // Kinds of result run that the front hands to the back.
  localparam logic [3:0] RUN_START    = 4'd0;
  localparam logic [3:0] RUN_DCP      = 4'd1;
  localparam logic [3:0] RUN_QC2_OK   = 4'd2;
  localparam logic [3:0] RUN_QC2_FAIL = 4'd3;
  localparam logic [3:0] RUN_9V       = 4'd4;
  localparam logic [3:0] RUN_12V      = 4'd5;
  localparam logic [3:0] RUN_20V      = 4'd6;
  localparam logic [3:0] RUN_RESTORE  = 4'd7;
  localparam logic [3:0] RUN_QC3_PRE  = 4'd8;
  localparam logic [3:0] RUN_QC3_POST = 4'd9;
  localparam logic [3:0] RUN_RELEASE  = 4'd10;
  localparam logic [3:0] RUN_PORT21   = 4'd11;
  localparam logic [3:0] RUN_PD       = 4'd12;

  typedef struct packed {
    logic [3:0] run;
    logic       ok;
  } job_t;

  // Which timer register a command result carries.
  localparam logic [1:0] TSEL_NONE    = 2'd0;
  localparam logic [1:0] TSEL_SETTLE  = 2'd1;
  localparam logic [1:0] TSEL_RELEASE = 2'd2;

  localparam int STEP_W = 3;

  typedef struct packed {
    logic       report_valid;
    logic [3:0] report_kind;
    logic       report_supported;
    logic [3:0] command;
    logic [1:0] tsel;
    logic       last;
  } entry_t;

  function automatic entry_t rep(logic [3:0] kind, logic ok, logic last);
    entry_t e;
    e.report_valid     = 1'b1;
    e.report_kind      = kind;
    e.report_supported = ok;
    e.command          = CMD_NONE;
    e.tsel             = TSEL_NONE;
    e.last             = last;
    return e;
  endfunction

  function automatic entry_t cmd(logic [3:0] code, logic [1:0] tsel, logic last);
    entry_t e;
    e.report_valid     = 1'b0;
    e.report_kind      = RK_FINISHED;
    e.report_supported = 1'b0;
    e.command          = code;
    e.tsel             = tsel;
    e.last             = last;
    return e;
  endfunction

  // Result number step of a run.
  function automatic entry_t run_entry(logic [3:0] run, logic [STEP_W-1:0] step, logic ok);
    entry_t e;
    e = cmd(CMD_NONE, TSEL_NONE, 1'b1);
    unique case (run)
      RUN_START:   e = cmd(CMD_PORT, TSEL_NONE, 1'b1);
      RUN_DCP:     e = (step == 3'd0) ? rep(RK_DCP, ok, 1'b0) : cmd(CMD_QC2, TSEL_NONE, 1'b1);
      RUN_QC2_OK:  e = (step == 3'd0) ? rep(RK_QC2, 1'b1, 1'b0) : cmd(CMD_9V, TSEL_SETTLE, 1'b1);
      RUN_QC2_FAIL: begin
        unique case (step)
          3'd0:    e = cmd(CMD_STOP_QC, TSEL_NONE, 1'b0);
          3'd1:    e = rep(RK_QC2, 1'b0, 1'b0);
          3'd2:    e = rep(RK_9V, 1'b0, 1'b0);
          3'd3:    e = rep(RK_12V, 1'b0, 1'b0);
          3'd4:    e = rep(RK_20V, 1'b0, 1'b0);
          3'd5:    e = rep(RK_QC3, 1'b0, 1'b0);
          default: e = cmd(CMD_PORT, TSEL_NONE, 1'b1);
        endcase
      end
      RUN_9V:      e = (step == 3'd0) ? rep(RK_9V, ok, 1'b0) : cmd(CMD_12V, TSEL_SETTLE, 1'b1);
      RUN_12V:     e = (step == 3'd0) ? rep(RK_12V, ok, 1'b0) : cmd(CMD_20V, TSEL_SETTLE, 1'b1);
      RUN_20V:     e = (step == 3'd0) ? rep(RK_20V, ok, 1'b0) : cmd(CMD_5V, TSEL_RELEASE, 1'b1);
      RUN_RESTORE: e = cmd(CMD_QC3_MODE, TSEL_SETTLE, 1'b1);
      RUN_QC3_PRE: e = cmd(CMD_QC3_UP, TSEL_SETTLE, 1'b1);
      RUN_QC3_POST: e = (step == 3'd0) ? rep(RK_QC3, ok, 1'b0)
                                       : cmd(CMD_STOP_QC, TSEL_RELEASE, 1'b1);
      RUN_RELEASE: e = cmd(CMD_PORT, TSEL_NONE, 1'b1);
      RUN_PORT21:  e = (step == 3'd0) ? rep(RK_PORT21, ok, 1'b0)
                                      : cmd(CMD_ENTER_PD, TSEL_NONE, 1'b1);
      RUN_PD: begin
        unique case (step)
          3'd0:    e = rep(RK_PD, ok, 1'b0);
          3'd1:    e = cmd(CMD_EXIT_PD, TSEL_NONE, 1'b0);
          default: e = rep(RK_FINISHED, 1'b1, 1'b1);
        endcase
      end
      default:     e = cmd(CMD_NONE, TSEL_NONE, 1'b1);
    endcase
    return e;
  endfunction

endpackage

>>> sv/cpps_front.sv
// Front end: takes event words, tracks the detection phase and queues result runs.
module cpps_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cpps_pkg::in_word_t in_data,
  input  cpps_pkg::cfg_t  cfg,
  output logic            push,
  output cpps_pkg::job_t  push_job,
  input  logic            q_full
);
  import cpps_pkg::*;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_DCP      = 4'd1;
  localparam logic [3:0] PH_QC2      = 4'd2;
  localparam logic [3:0] PH_9V       = 4'd3;
  localparam logic [3:0] PH_12V      = 4'd4;
  localparam logic [3:0] PH_20V      = 4'd5;
  localparam logic [3:0] PH_RESTORE  = 4'd6;
  localparam logic [3:0] PH_QC3_PRE  = 4'd7;
  localparam logic [3:0] PH_QC3_POST = 4'd8;
  localparam logic [3:0] PH_RELEASE  = 4'd9;
  localparam logic [3:0] PH_PORT21   = 4'd10;
  localparam logic [3:0] PH_PD       = 4'd11;

  localparam logic [8:0]  LVL_9V     = 9'd9;
  localparam logic [8:0]  LVL_12V    = 9'd12;
  localparam logic [8:0]  LVL_20V    = 9'd20;
  localparam logic [21:0] FRAC_SCALE = 22'd10000;

  logic        s1_valid_r;
  logic [2:0]  s1_func_r;
  logic        s1_ok_r;
  logic [7:0]  s1_volts_r;
  logic [21:0] s1_sample_r;
  logic [21:0] sample_nxt;

  logic [3:0]  phase_r, phase_nxt;
  logic [21:0] saved_r, saved_nxt;

  logic        ignored;
  logic [3:0]  run;
  logic        run_ok;
  logic        drain;
  logic        ok9, ok12, ok20, ok_qc3;
  logic [23:0] qc3_v, qc3_c, qc3_w;

  // Window compare written without negative bounds: v + w >= t and v <= t + w.
  function automatic logic level_ok(logic [7:0] volts, logic [8:0] target, logic [3:0] w);
    logic [8:0] v9;
    logic [8:0] w9;
    v9 = 9'(volts);
    w9 = 9'(w);
    return (v9 + w9 >= target) && (v9 <= target + w9);
  endfunction

  assign sample_nxt = 22'(22'(in_data.bus_volts) * FRAC_SCALE + 22'(in_data.bus_frac));

  assign ok9  = level_ok(s1_volts_r, LVL_9V,  cfg.qc2_window_volts);
  assign ok12 = level_ok(s1_volts_r, LVL_12V, cfg.qc2_window_volts);
  assign ok20 = level_ok(s1_volts_r, LVL_20V, cfg.qc2_window_volts);

  assign qc3_v  = 24'(s1_sample_r);
  assign qc3_c  = 24'(saved_r) + 24'(cfg.qc3_step_size);
  assign qc3_w  = 24'(cfg.qc3_window);
  assign ok_qc3 = (qc3_v + qc3_w >= qc3_c) && (qc3_v <= qc3_c + qc3_w);

  always_comb begin
    ignored   = 1'b1;
    run       = RUN_START;
    run_ok    = 1'b0;
    phase_nxt = phase_r;
    saved_nxt = saved_r;
    unique case (s1_func_r)
      EV_START: begin
        ignored   = 1'b0;
        run       = RUN_START;
        phase_nxt = PH_DCP;
      end
      EV_DCP: begin
        if (phase_r == PH_DCP) begin
          ignored   = 1'b0;
          run       = RUN_DCP;
          run_ok    = s1_ok_r;
          phase_nxt = PH_QC2;
        end
      end
      EV_QC2: begin
        if (phase_r == PH_QC2) begin
          ignored   = 1'b0;
          run       = s1_ok_r ? RUN_QC2_OK : RUN_QC2_FAIL;
          phase_nxt = s1_ok_r ? PH_9V : PH_PORT21;
        end
      end
      EV_TIMER: begin
        unique case (phase_r)
          PH_9V: begin
            ignored = 1'b0; run = RUN_9V; run_ok = ok9; phase_nxt = PH_12V;
          end
          PH_12V: begin
            ignored = 1'b0; run = RUN_12V; run_ok = ok12; phase_nxt = PH_20V;
          end
          PH_20V: begin
            ignored = 1'b0; run = RUN_20V; run_ok = ok20; phase_nxt = PH_RESTORE;
          end
          PH_RESTORE: begin
            ignored = 1'b0; run = RUN_RESTORE; phase_nxt = PH_QC3_PRE;
          end
          PH_QC3_PRE: begin
            ignored   = 1'b0;
            run       = RUN_QC3_PRE;
            phase_nxt = PH_QC3_POST;
            saved_nxt = s1_sample_r;
          end
          PH_QC3_POST: begin
            ignored = 1'b0; run = RUN_QC3_POST; run_ok = ok_qc3; phase_nxt = PH_RELEASE;
          end
          PH_RELEASE: begin
            ignored = 1'b0; run = RUN_RELEASE; phase_nxt = PH_PORT21;
          end
          default: ignored = 1'b1;
        endcase
      end
      EV_PORT21: begin
        if (phase_r == PH_PORT21) begin
          ignored   = 1'b0;
          run       = RUN_PORT21;
          run_ok    = s1_ok_r;
          phase_nxt = PH_PD;
        end
      end
      EV_PD: begin
        if (phase_r == PH_PD) begin
          ignored   = 1'b0;
          run       = RUN_PD;
          run_ok    = s1_ok_r;
          phase_nxt = PH_IDLE;
        end
      end
      default: ignored = 1'b1;
    endcase
  end

  // An ignored event leaves the stage without needing queue space.
  assign drain        = s1_valid_r && (ignored || !q_full);
  assign in_ready     = !s1_valid_r || drain;
  assign push         = s1_valid_r && !ignored && !q_full;
  assign push_job.run = run;
  assign push_job.ok  = run_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= PH_IDLE;
      saved_r    <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (drain) begin
        phase_r <= phase_nxt;
        saved_r <= saved_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func_r   <= in_data.func;
      s1_ok_r     <= in_data.probe_ok;
      s1_volts_r  <= in_data.bus_volts;
      s1_sample_r <= sample_nxt;
    end
  end

endmodule

>>> sv/cpps_queue.sv
// Small first-in first-out queue of result runs between front and back.
module cpps_queue #(
  parameter int DEPTH = cpps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cpps_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output cpps_pkg::job_t head_job
);
  import cpps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> sv/cpps_back.sv
// Back end: expands each queued run into result words, one per clock while the output is not stalled.
module cpps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  cpps_pkg::job_t      head_job,
  output logic                pop,
  input  cpps_pkg::cfg_t      cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output cpps_pkg::out_word_t out_data
);
  import cpps_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  out_word_t         out_r, out_nxt;
  entry_t            ent;
  logic              load;

  assign ent  = run_entry(head_job.run, step_r, head_job.ok);
  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && ent.last;

  always_comb begin
    out_nxt.report_valid     = ent.report_valid;
    out_nxt.report_kind      = ent.report_kind;
    out_nxt.report_supported = ent.report_supported;
    out_nxt.command          = ent.command;
    out_nxt.last             = ent.last;
    unique case (ent.tsel)
      TSEL_SETTLE:  out_nxt.timer_ms = cfg.settle_time_ms;
      TSEL_RELEASE: out_nxt.timer_ms = cfg.release_time_ms;
      default:      out_nxt.timer_ms = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        step_r      <= ent.last ? '0 : step_r + 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> sv/charger_protocol_probe_sequencer.sv
// Top level of the charger protocol probe sequencer: configuration registers and the datapath.
//
// The sequencer steps through charger detection in a fixed order: dedicated
// port, QC2.0 handshake, QC2.0 level checks at 9 V, 12 V and 20 V, return to
// 5 V, a QC3.0 single-step rise check, a release, the 2.1 A port probe and
// finally PD. Each input word is one event (start, a sub-probe result, or a
// timer expiry carrying a bus voltage sample); the block answers it with a
// run of one to seven output words, each a support report or a command with
// a timer request, the final word of the run flagged with last. An event that
// does not fit the current phase produces no words, and start restarts
// detection from any phase. The front end registers the event (the voltage
// sample volts*10000+frac is formed there), then classifies it against the
// phase in the next cycle and pushes its run into the run queue, and a new
// event is accepted every clock while the queue has room. The back end
// drains the queue at one output word per clock through its output
// register while the output is not stalled, so the output port sets the
// sustained rate, and the longest run is seven words.
// Configuration registers are written through the cfg port, which is always
// ready; they must only be written while no event is in flight.
module charger_protocol_probe_sequencer #(
  parameter int QUEUE_DEPTH = cpps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cpps_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cpps_pkg::out_word_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cpps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import cpps_pkg::*;

  cfg_t cfg_r;
  logic push, q_full, pop, head_valid;
  job_t push_job, head_job;

  // Register writes are always accepted; indexes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.qc2_window_volts <= RST_QC2_WINDOW;
      cfg_r.qc3_step_size    <= RST_QC3_STEP;
      cfg_r.qc3_window       <= RST_QC3_WINDOW;
      cfg_r.settle_time_ms   <= RST_SETTLE;
      cfg_r.release_time_ms  <= RST_RELEASE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_QC2_WINDOW: cfg_r.qc2_window_volts <= cfg_data[3:0];
        REG_QC3_STEP:   cfg_r.qc3_step_size    <= cfg_data;
        REG_QC3_WINDOW: cfg_r.qc3_window       <= cfg_data;
        REG_SETTLE:     cfg_r.settle_time_ms   <= cfg_data;
        REG_RELEASE:    cfg_r.release_time_ms  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front end: event register, phase tracking and window compares.
  cpps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  // Run queue that lets the front keep taking events while results drain.
  cpps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back end: one result word per clock, while the output is not stalled, into the output register.
  cpps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .cfg        (cfg_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
